/* rtl/core/wpc_pkg.sv */
// Shared types and constants of the window polygon clipper.
`timescale 1ns / 1ps

package wpc_pkg;

    localparam int NUM_ATTR  = 7;
    localparam int ATTR_W    = 32;
    localparam int ATTR_X    = 0;
    localparam int ATTR_Y    = 1;
    localparam int MIN_POLY  = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 8'd3;

    localparam logic signed [ATTR_W-1:0] WIN_LEFT_RST   = 32'sd0;
    localparam logic signed [ATTR_W-1:0] WIN_RIGHT_RST  = 32'sd41943040;
    localparam logic signed [ATTR_W-1:0] WIN_TOP_RST    = 32'sd0;
    localparam logic signed [ATTR_W-1:0] WIN_BOTTOM_RST = 32'sd31457280;

    // Attribute order: x, y, z, rhw, shade, u, v.
    typedef logic [NUM_ATTR-1:0][ATTR_W-1:0] t_vtx;

    typedef struct packed {
        logic                start;
        logic [ATTR_W:0]     num;
        logic [ATTR_W:0]     den;
    } t_div_req;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_PREV,
        S_NEXT,
        S_CUR,
        S_DSTART,
        S_DWAIT,
        S_LERP,
        S_WR,
        S_EMITB,
        S_ADV,
        S_PDONE,
        S_ERD,
        S_EOUT,
        S_REJ
    } t_state;

endpackage

/* rtl/core/wpc_vram.sv */
// Vertex memory with one write port and one registered read port.
`timescale 1ns / 1ps

module wpc_vram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  wpc_pkg::t_vtx   i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output wpc_pkg::t_vtx   o_rdata
);

    wpc_pkg::t_vtx r_mem [DEPTH];
    wpc_pkg::t_vtx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/wpc_div.sv */
// Bit-serial divider for the clip factor, limited to one.
`timescale 1ns / 1ps

module wpc_div #(
    parameter int FRAC = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wpc_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [FRAC:0]     o_t
);

    localparam int DW = wpc_pkg::ATTR_W + 1;
    localparam int CNTW = $clog2(FRAC + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [FRAC:0]   r_q;
    logic [DW:0]     rem2;

    assign rem2 = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den == '0) begin
                    r_q    <= '0;
                    r_done <= 1'b1;
                end else if (i_req.num >= i_req.den) begin
                    r_q    <= {1'b1, {FRAC{1'b0}}};
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_req.num;
                    r_den  <= i_req.den;
                    r_q    <= '0;
                    r_cnt  <= CNTW'(FRAC);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (rem2 >= {1'b0, r_den}) begin
                    r_rem <= DW'(rem2 - {1'b0, r_den});
                    r_q   <= {r_q[FRAC-1:0], 1'b1};
                end else begin
                    r_rem <= rem2[DW-1:0];
                    r_q   <= {r_q[FRAC-1:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_t    = r_q;

endmodule

/* rtl/core/window_polygon_clipper_top.sv */
// Top level of the window polygon clipper: sequencer, interpolator and stream ports.
`timescale 1ns / 1ps

// Vertices are taken one word per cycle into a vertex memory. After the word with
// tlast, no input is taken while the polygon is clipped against the left and right
// edges into a second memory and then against the top and bottom edges back into
// the first. Each crossing is computed by the bit-serial divider, which answers at
// once when the factor is limited to one, and by the shared multiplier that
// interpolates the seven attributes in turn. Results then leave one word at a
// time, each read from the vertex memory before it is sent; a rejected polygon
// gives one word with tlast set. Vertices beyond MAX_VERTS are dropped and flagged.
module window_polygon_clipper_top #(
    parameter int MAX_VERTS      = 16,
    parameter int CLIP_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_x, pos_y, pos_z, recip_w, shade, tex_u, tex_v
    input  logic [223:0]                  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x, out_y, out_z, out_rhw, out_shade, out_u, out_v
    output logic [223:0]                  m_axis_tdata,
    output logic                          m_axis_tlast,
    // rejected, overflowed
    output logic [1:0]                    m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam int TW = CLIP_FRAC_BITS + 1;
    localparam int PW = wpc_pkg::ATTR_W + TW + 2;

    wpc_pkg::t_state r_state, n_state;

    logic signed [31:0] r_left, r_right, r_top, r_bottom;
    logic [CW-1:0] r_lcnt, r_n, r_ocnt;
    logic          r_lovf, r_ovf, r_pass;
    logic [AW-1:0] r_i, r_j;
    wpc_pkg::t_vtx r_a, r_b, r_v;
    logic          r_x2, r_second;
    logic signed [31:0] r_e2, r_edge;
    logic [TW-1:0] r_t;
    logic [2:0]    r_k, r_pk;
    logic          r_pv;
    logic signed [PW-1:0] r_prod;
    logic          r_mvalid, r_mlast;
    wpc_pkg::t_vtx r_mdata;
    logic [1:0]    r_muser;

    wpc_pkg::t_vtx rd_a, rd_b, src, wdata;
    logic          in_acc, out_free, we_a, we_b, re, dst_we, load_we;
    logic [AW-1:0] raddr, waddr;
    wpc_pkg::t_div_req div_req;
    logic          div_done;
    logic [TW-1:0] div_t;

    logic signed [31:0] lo, hi, ac, bc, cur_ac, cur_bc, e1, e2;
    logic               skip, x1, x2;
    logic [2:0]         axis;
    logic signed [32:0] dnum, dden, ddiff;
    logic [2:0]         k_idx;
    logic signed [PW-1:0] prod, sh;
    wpc_pkg::t_vtx      cross_v;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_mvalid || m_axis_tready;
    assign s_axis_tready = (r_state == wpc_pkg::S_LOAD);
    assign o_cfg_ready   = 1'b1;

    assign axis = r_pass ? 3'(wpc_pkg::ATTR_Y) : 3'(wpc_pkg::ATTR_X);
    assign lo   = r_pass ? r_top : r_left;
    assign hi   = r_pass ? r_bottom : r_right;
    assign src  = r_pass ? rd_b : rd_a;

    assign cur_ac = r_a[axis];
    assign cur_bc = src[axis];
    assign skip = ((cur_ac < lo) && (cur_bc < lo)) ||
                  (!(cur_ac < lo) && (cur_ac > hi) && (cur_bc > hi));
    assign x1 = !skip && ((cur_ac < lo) || (cur_ac > hi));
    assign e1 = (cur_ac < lo) ? lo : hi;
    assign x2 = !skip && ((cur_bc < lo) || (cur_bc > hi));
    assign e2 = (cur_bc < lo) ? lo : hi;

    assign ac = r_a[axis];
    assign bc = r_b[axis];
    assign dnum = 33'(r_edge) - 33'(bc);
    assign dden = 33'(ac) - 33'(bc);
    assign div_req.start = (r_state == wpc_pkg::S_DSTART);
    assign div_req.num   = dnum[32] ? 33'(-dnum) : dnum;
    assign div_req.den   = dden[32] ? 33'(-dden) : dden;

    assign k_idx = (r_k == 3'd7) ? 3'd0 : r_k;
    assign ddiff = 33'($signed(r_a[k_idx])) - 33'($signed(r_b[k_idx]));
    assign prod  = PW'(ddiff) * PW'($signed({1'b0, r_t}));
    assign sh    = r_prod >>> CLIP_FRAC_BITS;

    always_comb begin
        cross_v       = r_v;
        cross_v[axis] = r_edge;
    end

    // Memory control.
    assign load_we = in_acc && (r_lcnt < CW'(MAX_VERTS));
    assign dst_we  = ((r_state == wpc_pkg::S_WR) || (r_state == wpc_pkg::S_EMITB)) &&
                     (r_ocnt < CW'(MAX_VERTS));
    assign we_a  = load_we || (dst_we && r_pass);
    assign we_b  = dst_we && !r_pass;
    assign waddr = (r_state == wpc_pkg::S_LOAD) ? r_lcnt[AW-1:0] : r_ocnt[AW-1:0];
    assign wdata = (r_state == wpc_pkg::S_LOAD) ? wpc_pkg::t_vtx'(s_axis_tdata) :
                   (r_state == wpc_pkg::S_WR) ? cross_v : r_b;
    assign re    = (r_state == wpc_pkg::S_START) || (r_state == wpc_pkg::S_NEXT) ||
                   (r_state == wpc_pkg::S_ERD);
    assign raddr = (r_state == wpc_pkg::S_START) ? AW'(r_n - 1'b1) :
                   (r_state == wpc_pkg::S_NEXT) ? r_i : r_j;

    wpc_vram #(.DEPTH(MAX_VERTS), .AW(AW)) u_mem_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr), .o_rdata(rd_a)
    );

    wpc_vram #(.DEPTH(MAX_VERTS), .AW(AW)) u_mem_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr), .o_rdata(rd_b)
    );

    wpc_div #(.FRAC(CLIP_FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_t(div_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpc_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wpc_pkg::S_LOAD: begin
                if (in_acc && s_axis_tlast) n_state = wpc_pkg::S_START;
            end
            wpc_pkg::S_START: begin
                n_state = (r_n < CW'(wpc_pkg::MIN_POLY)) ? wpc_pkg::S_REJ : wpc_pkg::S_PREV;
            end
            wpc_pkg::S_PREV:   n_state = wpc_pkg::S_NEXT;
            wpc_pkg::S_NEXT:   n_state = wpc_pkg::S_CUR;
            wpc_pkg::S_CUR: begin
                if (skip) n_state = wpc_pkg::S_ADV;
                else if (x1 || x2) n_state = wpc_pkg::S_DSTART;
                else n_state = wpc_pkg::S_EMITB;
            end
            wpc_pkg::S_DSTART: n_state = wpc_pkg::S_DWAIT;
            wpc_pkg::S_DWAIT: begin
                if (div_done) n_state = wpc_pkg::S_LERP;
            end
            wpc_pkg::S_LERP: begin
                if (r_k == 3'd7) n_state = wpc_pkg::S_WR;
            end
            wpc_pkg::S_WR: begin
                if (!r_second) n_state = r_x2 ? wpc_pkg::S_DSTART : wpc_pkg::S_EMITB;
                else n_state = wpc_pkg::S_ADV;
            end
            wpc_pkg::S_EMITB:  n_state = wpc_pkg::S_ADV;
            wpc_pkg::S_ADV: begin
                n_state = (CW'(r_i) + 1'b1 == r_n) ? wpc_pkg::S_PDONE : wpc_pkg::S_NEXT;
            end
            wpc_pkg::S_PDONE: begin
                if (!r_pass) n_state = wpc_pkg::S_START;
                else if (r_ocnt < CW'(wpc_pkg::MIN_POLY)) n_state = wpc_pkg::S_REJ;
                else n_state = wpc_pkg::S_ERD;
            end
            wpc_pkg::S_ERD:    n_state = wpc_pkg::S_EOUT;
            wpc_pkg::S_EOUT: begin
                if (out_free) begin
                    n_state = (CW'(r_j) + 1'b1 == r_n) ? wpc_pkg::S_LOAD : wpc_pkg::S_ERD;
                end
            end
            wpc_pkg::S_REJ: begin
                if (out_free) n_state = wpc_pkg::S_LOAD;
            end
            default: n_state = wpc_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= wpc_pkg::WIN_LEFT_RST;
            r_right  <= wpc_pkg::WIN_RIGHT_RST;
            r_top    <= wpc_pkg::WIN_TOP_RST;
            r_bottom <= wpc_pkg::WIN_BOTTOM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wpc_pkg::REG_WIN_LEFT:   r_left   <= i_cfg_data;
                wpc_pkg::REG_WIN_RIGHT:  r_right  <= i_cfg_data;
                wpc_pkg::REG_WIN_TOP:    r_top    <= i_cfg_data;
                wpc_pkg::REG_WIN_BOTTOM: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt <= '0;
            r_lovf <= 1'b0;
            r_ovf  <= 1'b0;
            r_pass <= 1'b0;
            r_ocnt <= '0;
            r_n    <= '0;
            r_pv   <= 1'b0;
            r_k    <= '0;
        end else begin
            case (r_state)
                wpc_pkg::S_LOAD: begin
                    if (in_acc) begin
                        if (s_axis_tlast) begin
                            r_n    <= load_we ? CW'(r_lcnt + 1'b1) : r_lcnt;
                            r_ovf  <= r_lovf || !load_we;
                            r_lcnt <= '0;
                            r_lovf <= 1'b0;
                            r_pass <= 1'b0;
                            r_ocnt <= '0;
                        end else if (load_we) begin
                            r_lcnt <= CW'(r_lcnt + 1'b1);
                        end else begin
                            r_lovf <= 1'b1;
                        end
                    end
                end
                wpc_pkg::S_PREV: begin
                    r_a <= src;
                    r_i <= '0;
                end
                wpc_pkg::S_CUR: begin
                    r_b      <= src;
                    r_x2     <= x2;
                    r_e2     <= e2;
                    r_edge   <= x1 ? e1 : e2;
                    r_second <= !x1;
                end
                wpc_pkg::S_DWAIT: begin
                    if (div_done) begin
                        r_t  <= div_t;
                        r_k  <= '0;
                        r_pv <= 1'b0;
                    end
                end
                wpc_pkg::S_LERP: begin
                    if (r_k != 3'd7) begin
                        r_prod <= prod;
                        r_pk   <= r_k;
                        r_pv   <= 1'b1;
                        r_k    <= r_k + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_v[r_pk] <= r_b[r_pk] + sh[31:0];
                    end
                end
                wpc_pkg::S_WR, wpc_pkg::S_EMITB: begin
                    if (dst_we) r_ocnt <= CW'(r_ocnt + 1'b1);
                    else r_ovf <= 1'b1;
                    if ((r_state == wpc_pkg::S_WR) && !r_second && r_x2) begin
                        r_edge   <= r_e2;
                        r_second <= 1'b1;
                    end
                end
                wpc_pkg::S_ADV: begin
                    r_a <= r_b;
                    r_i <= r_i + 1'b1;
                end
                wpc_pkg::S_PDONE: begin
                    r_n    <= r_ocnt;
                    r_ocnt <= '0;
                    r_pass <= 1'b1;
                    r_j    <= '0;
                end
                wpc_pkg::S_EOUT: begin
                    if (out_free) r_j <= r_j + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else begin
            if (r_mvalid && m_axis_tready) r_mvalid <= 1'b0;
            if (out_free && (r_state == wpc_pkg::S_EOUT)) begin
                r_mvalid <= 1'b1;
                r_mdata  <= rd_a;
                r_mlast  <= (CW'(r_j) + 1'b1 == r_n);
                r_muser  <= {r_ovf, 1'b0};
            end else if (out_free && (r_state == wpc_pkg::S_REJ)) begin
                r_mvalid <= 1'b1;
                r_mdata  <= '0;
                r_mlast  <= 1'b1;
                r_muser  <= {r_ovf, 1'b1};
            end
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;
    assign m_axis_tuser  = r_muser;

endmodule

/* rtl/core/wpc_checker.sv */
// Port checker for the window polygon clipper and its bind.
`timescale 1ns / 1ps

module wpc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [223:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic [1:0]   m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_rej_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("rejected word without tlast");

    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("rejected word carries vertex data");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken while clipping");

endmodule

bind window_polygon_clipper_top wpc_checker u_wpc_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
);
